>>> src/ctk_pkg.sv
`default_nettype none

package ctk_pkg;

   localparam int KEY_W   = 16;
   localparam int COUNT_W = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // opcodes; anything else reads as a query
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_USE = 2'd1;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_ABSENT = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [KEY_W-1:0]   item_key;
      logic [COUNT_W-1:0] add_amount;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [COUNT_W-1:0] count_now;
   } rsp_type;

   // operation travelling down the row of slot cells
   typedef struct packed {
      logic               valid;
      logic [1:0]         opcode;
      logic [KEY_W-1:0]   item_key;
      logic [COUNT_W-1:0] add_amount;
      logic               found;     // key matched in an earlier cell
      logic               claimed;   // add took the first free slot
      logic               shift;     // slot emptied: later slots move down
      logic               empty_use; // use hit a slot whose count is zero
      logic [COUNT_W-1:0] count;     // count after the operation
   } token_type;

endpackage

`default_nettype wire

>>> src/ctk_cell.sv
`default_nettype none

module ctk_cell #(
   parameter int SLOTS = 16,
   parameter int IDX   = 0
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire  [$clog2(SLOTS+1)-1:0]           used,
   input  ctk_pkg::token_type                   tok_in,
   output ctk_pkg::token_type                   tok_out,
   input  wire  [ctk_pkg::KEY_W-1:0]            up_key,
   input  wire  [ctk_pkg::COUNT_W-1:0]          up_count,
   output logic [ctk_pkg::KEY_W-1:0]            key_out,
   output logic [ctk_pkg::COUNT_W-1:0]          count_out
);

   localparam int UsedW = $clog2(SLOTS+1);

   ctk_pkg::token_type tok_ff, tok_in_n;
   logic [ctk_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [ctk_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [ctk_pkg::COUNT_W:0]   sum;
   logic [ctk_pkg::COUNT_W-1:0] sat;
   logic                        in_use, at_free, hit;

   always_comb begin
      sum      = {1'b0, count_ff} + {1'b0, tok_in.add_amount};
      sat      = sum[ctk_pkg::COUNT_W] ? ctk_pkg::COUNT_MAX : sum[ctk_pkg::COUNT_W-1:0];
      in_use   = used > UsedW'(IDX);
      at_free  = used == UsedW'(IDX);
      hit      = tok_in.valid && in_use && !tok_in.found && (key_ff == tok_in.item_key);
      tok_in_n = tok_in;
      key_in   = key_ff;
      count_in = count_ff;
      if (tok_in.valid) begin
         if (tok_in.shift && in_use) begin
            // compaction: take the upper neighbour's slot
            key_in   = up_key;
            count_in = up_count;
         end else if (hit) begin
            tok_in_n.found = 1'b1;
            case (tok_in.opcode)
               ctk_pkg::OP_ADD: begin
                  count_in       = sat;
                  tok_in_n.count = sat;
               end
               ctk_pkg::OP_USE: begin
                  if (count_ff == '0) begin
                     tok_in_n.empty_use = 1'b1;
                     tok_in_n.count     = '0;
                  end else if (count_ff == ctk_pkg::COUNT_W'(1)) begin
                     tok_in_n.shift = 1'b1;
                     tok_in_n.count = '0;
                     key_in         = up_key;
                     count_in       = up_count;
                  end else begin
                     count_in       = count_ff - ctk_pkg::COUNT_W'(1);
                     tok_in_n.count = count_ff - ctk_pkg::COUNT_W'(1);
                  end
               end
               default: begin
                  tok_in_n.count = count_ff;
               end
            endcase
         end else if (at_free && !tok_in.found && tok_in.opcode == ctk_pkg::OP_ADD) begin
            key_in           = tok_in.item_key;
            count_in         = tok_in.add_amount;
            tok_in_n.claimed = 1'b1;
            tok_in_n.count   = tok_in.add_amount;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_n;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      count_ff <= count_in;
   end

   assign tok_out   = tok_ff;
   assign key_out   = key_ff;
   assign count_out = count_ff;

endmodule

`default_nettype wire

>>> src/counted_key_table.sv
// The result strobe follows the beat's walk through the row: the beat is registered in the
// entry register, then in each slot cell in turn, then in the result register.
// A new beat is taken only while busy is low; the operation walks the row of slot
// cells one cell per cycle, busy covers the whole walk.
// Reset empties the table (fill count to zero); slot contents are left as they are.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
`default_nettype none

module counted_key_table #(
   parameter int SLOTS = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  ctk_pkg::req_type       req_item,
   output logic                   rsp_valid,
   output ctk_pkg::rsp_type       rsp_item
);

   localparam int UsedW = $clog2(SLOTS+1);

   ctk_pkg::token_type entry_ff, entry_in;
   ctk_pkg::token_type chain [SLOTS+1];
   ctk_pkg::token_type fin;

   logic [ctk_pkg::KEY_W-1:0]   cell_key   [SLOTS];
   logic [ctk_pkg::COUNT_W-1:0] cell_count [SLOTS];
   logic [SLOTS-1:0]            tok_valid;

   logic             busy_ff, busy_in;
   logic [UsedW-1:0] used_ff, used_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ctk_pkg::rsp_type rsp_item_ff, rsp_item_in;
   logic             accept;

   assign accept = start && !busy_ff;

   // new beat enters the head of the row
   always_comb begin
      entry_in = '0;
      if (accept) begin
         entry_in.valid      = 1'b1;
         entry_in.opcode     = req_item.opcode;
         entry_in.item_key   = req_item.item_key;
         entry_in.add_amount = req_item.add_amount;
      end
   end

   assign chain[0] = entry_ff;

   genvar g;
   generate
      for (g = 0; g < SLOTS; g++) begin : g_cell
         logic [ctk_pkg::KEY_W-1:0]   up_key;
         logic [ctk_pkg::COUNT_W-1:0] up_count;
         if (g == SLOTS-1) begin : g_last
            // top slot has no neighbour; what it loads is beyond the fill count
            assign up_key   = cell_key[g];
            assign up_count = cell_count[g];
         end else begin : g_mid
            assign up_key   = cell_key[g+1];
            assign up_count = cell_count[g+1];
         end
         ctk_cell #(
            .SLOTS (SLOTS),
            .IDX   (g)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .used      (used_ff),
            .tok_in    (chain[g]),
            .tok_out   (chain[g+1]),
            .up_key    (up_key),
            .up_count  (up_count),
            .key_out   (cell_key[g]),
            .count_out (cell_count[g])
         );
         assign tok_valid[g] = chain[g+1].valid;
      end
   endgenerate

   assign fin = chain[SLOTS];

   // result and fill count once the beat leaves the last cell
   always_comb begin
      busy_in      = busy_ff;
      used_in      = used_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (fin.valid) begin
         busy_in               = 1'b0;
         rsp_valid_in          = 1'b1;
         rsp_item_in.status    = ctk_pkg::STATUS_OK;
         rsp_item_in.count_now = fin.count;
         if (fin.opcode == ctk_pkg::OP_ADD && !fin.found && !fin.claimed) begin
            rsp_item_in.status    = ctk_pkg::STATUS_FULL;
            rsp_item_in.count_now = '0;
         end else if (fin.opcode == ctk_pkg::OP_USE && (!fin.found || fin.empty_use)) begin
            rsp_item_in.status = ctk_pkg::STATUS_ABSENT;
         end
         if (fin.claimed) begin
            used_in = used_ff + UsedW'(1);
         end else if (fin.shift) begin
            used_in = used_ff - UsedW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff     <= '0;
         busy_ff      <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         entry_ff     <= entry_in;
         busy_ff      <= busy_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // at most one beat in the row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0({tok_valid, entry_ff.valid}))
      else $error("more than one beat in the cell row");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UsedW'(SLOTS))
      else $error("fill count beyond table size");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("beat taken but block not busy");

   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy_ff)
      else $error("result strobe while still busy");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.status == ctk_pkg::STATUS_FULL)
         |-> (rsp_item_ff.count_now == '0 && $past(used_ff) == UsedW'(SLOTS)))
      else $error("table-full result with a free slot or nonzero count");

endmodule

`default_nettype wire
